### rtl/rcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcm_pkg;

    // Width of the segment-width register as seen on the configuration port
    localparam int FOLD_W = 6;

    // Defaults for the top-level parameters
    localparam int WORD_BITS_DEF     = 64;
    localparam int MAX_FOLD_BITS_DEF = 32;

    // Segment width after reset
    localparam int FOLD_RESET = 16;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FOLD_BITS     = 1'b0,
        CFG_REFERENCE_SUM = 1'b1
    } t_cfg_index;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FOLD = 3'b010,
        S_SUM  = 3'b100
    } t_state;

endpackage

`default_nettype wire

### rtl/residue_checksum_mod_2k_plus_1.sv
`timescale 1ns / 1ps
`default_nettype none

// Residue checker modulo 2^k+1. Each request carries one data word, which is
// cut into k-bit digits from bit 0 upwards and summed with alternating signs,
// giving the word's residue in 0..2^k. The residues are summed modulo 2^k+1
// into a running block sum (cleared by first_word); on last_word the sum is
// compared with reference_sum. The word and the held running sum are shifted
// out one k-bit digit per cycle through two shift registers that share one
// digit counter. A finished result sits in an output register, so the next
// request is taken while it waits; the block stalls only when a second result
// is ready before the first has been taken. fold_bits below 2 acts as 2, above
// MAX_FOLD_BITS as MAX_FOLD_BITS. Both ready outputs stay low while reset is
// held. Write configuration only while idle.

module residue_checksum_mod_2k_plus_1 #(
    parameter int WORD_BITS     = rcm_pkg::WORD_BITS_DEF,
    parameter int MAX_FOLD_BITS = rcm_pkg::MAX_FOLD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    // configuration write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [0:0]                   i_cfg_index,
    input  wire logic [((MAX_FOLD_BITS + 1) > rcm_pkg::FOLD_W ?
                        (MAX_FOLD_BITS + 1) : rcm_pkg::FOLD_W) - 1:0] i_cfg_data,

    // request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [WORD_BITS-1:0]         i_data_word,
    input  wire logic                         i_first_word,
    input  wire logic                         i_last_word,

    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [MAX_FOLD_BITS:0]            o_word_residue,
    output logic [MAX_FOLD_BITS:0]            o_block_sum,
    output logic                              o_block_end,
    output logic                              o_sum_mismatch
);

    localparam int RES_W     = MAX_FOLD_BITS + 1;
    localparam int ACC_W     = RES_W + 1;
    localparam int LOOP_BITS = (WORD_BITS > RES_W) ? WORD_BITS : RES_W;
    localparam int CNT_W     = $clog2(LOOP_BITS + 1);
    localparam int FW        = rcm_pkg::FOLD_W;
    localparam int K_RESET   = (rcm_pkg::FOLD_RESET > MAX_FOLD_BITS) ?
                               MAX_FOLD_BITS : rcm_pkg::FOLD_RESET;

    // Clamp a raw segment width into 2..MAX_FOLD_BITS.
    function automatic logic [FW-1:0] f_clamp(input logic [FW-1:0] raw);
        logic [FW-1:0] k;
        k = raw;
        if (k < FW'(2)) begin
            k = FW'(2);
        end
        if (k > FW'(MAX_FOLD_BITS)) begin
            k = FW'(MAX_FOLD_BITS);
        end
        return k;
    endfunction

    // One digit of the alternating-sign fold: acc +/- seg modulo m.
    // acc < m and seg < m, so one conditional subtract is enough.
    function automatic logic [RES_W-1:0] f_fold_step(
        input logic [RES_W-1:0]         acc,
        input logic [MAX_FOLD_BITS-1:0] seg,
        input logic                     neg,
        input logic [RES_W-1:0]         m
    );
        logic [ACC_W-1:0] addend;
        logic [ACC_W-1:0] s;
        addend = neg ? (ACC_W'(m) - ACC_W'(seg)) : ACC_W'(seg);
        s      = ACC_W'(acc) + addend;
        if (s >= ACC_W'(m)) begin
            s = s - ACC_W'(m);
        end
        return s[RES_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration: hold the effective k together with its modulus and
    // digit mask, so that the fold loop sees them straight from registers.
    // ------------------------------------------------------------------
    logic [FW-1:0]            r_k;
    logic [RES_W-1:0]         r_mod;
    logic [MAX_FOLD_BITS-1:0] r_mask;
    logic [RES_W-1:0]         r_ref;

    logic [FW-1:0]            n_k;

    // refuse writes while reset is held
    assign o_cfg_ready = i_rst_n;
    assign n_k         = f_clamp(i_cfg_data[FW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= FW'(K_RESET);
            r_mod  <= (RES_W'(1) << K_RESET) + RES_W'(1);
            r_mask <= ~({MAX_FOLD_BITS{1'b1}} << K_RESET);
            r_ref  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rcm_pkg::t_cfg_index'(i_cfg_index))
                rcm_pkg::CFG_FOLD_BITS: begin
                    r_k    <= n_k;
                    r_mod  <= (RES_W'(1) << n_k) + RES_W'(1);
                    r_mask <= ~({MAX_FOLD_BITS{1'b1}} << n_k);
                end
                rcm_pkg::CFG_REFERENCE_SUM: begin
                    r_ref <= i_cfg_data[RES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and digit-serial datapath
    // ------------------------------------------------------------------
    rcm_pkg::t_state r_state;

    logic [LOOP_BITS-1:0] r_word_sh;   // data word, shifted down k bits a cycle
    logic [RES_W-1:0]     r_rs_sh;     // held running sum, shifted alongside
    logic [RES_W-1:0]     r_acc_w;     // residue of the word so far
    logic [RES_W-1:0]     r_acc_s;     // residue of the held running sum so far
    logic                 r_neg;       // sign of the current digit
    logic [CNT_W-1:0]     r_left;      // bits still to be folded
    logic                 r_first;
    logic                 r_last;
    logic [RES_W-1:0]     r_running_sum;

    logic [RES_W-1:0]     n_acc_w;
    logic [RES_W-1:0]     n_acc_s;
    logic                 w_last_digit;
    logic [ACC_W-1:0]     w_sum_raw;
    logic [RES_W-1:0]     n_sum;
    logic                 w_out_free;

    assign o_in_ready   = i_rst_n && (r_state == rcm_pkg::S_IDLE);
    assign w_last_digit = (r_left <= CNT_W'(r_k));
    assign w_out_free   = !o_out_valid || i_out_ready;

    assign n_acc_w = f_fold_step(r_acc_w, r_word_sh[MAX_FOLD_BITS-1:0] & r_mask,
                                 r_neg, r_mod);
    assign n_acc_s = f_fold_step(r_acc_s, r_rs_sh[MAX_FOLD_BITS-1:0] & r_mask,
                                 r_neg, r_mod);

    // Close the word: add its residue to the (reduced or cleared) block sum.
    always_comb begin
        w_sum_raw = ACC_W'(r_first ? '0 : r_acc_s) + ACC_W'(r_acc_w);
        if (w_sum_raw >= ACC_W'(r_mod)) begin
            w_sum_raw = w_sum_raw - ACC_W'(r_mod);
        end
        n_sum = w_sum_raw[RES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rcm_pkg::S_IDLE;
            r_running_sum <= '0;
        end else begin
            unique case (r_state)
                rcm_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= rcm_pkg::S_FOLD;
                    end
                end
                rcm_pkg::S_FOLD: begin
                    if (w_last_digit) begin
                        r_state <= rcm_pkg::S_SUM;
                    end
                end
                rcm_pkg::S_SUM: begin
                    // hold here until the output register is free
                    if (w_out_free) begin
                        r_running_sum <= n_sum;
                        r_state       <= rcm_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= rcm_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: load on a request, advance one digit per cycle while folding.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word_sh <= LOOP_BITS'(i_data_word);
            r_rs_sh   <= r_running_sum;
            r_acc_w   <= '0;
            r_acc_s   <= '0;
            r_neg     <= 1'b0;
            r_left    <= CNT_W'(LOOP_BITS);
            r_first   <= i_first_word;
            r_last    <= i_last_word;
        end else if (r_state == rcm_pkg::S_FOLD) begin
            r_word_sh <= r_word_sh >> r_k;
            r_rs_sh   <= r_rs_sh >> r_k;
            r_acc_w   <= n_acc_w;
            r_acc_s   <= n_acc_s;
            r_neg     <= !r_neg;
            r_left    <= w_last_digit ? '0 : (r_left - CNT_W'(r_k));
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == rcm_pkg::S_SUM && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rcm_pkg::S_SUM && w_out_free) begin
            o_word_residue <= r_acc_w;
            o_block_sum    <= n_sum;
            o_block_end    <= r_last;
            o_sum_mismatch <= r_last && (n_sum != r_ref);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcm_pkg::S_FOLD) |-> (r_acc_w < r_mod) && (r_acc_s < r_mod))
        else $error("fold accumulator left 0..2^k");

    a_request_starts_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == rcm_pkg::S_FOLD))
        else $error("request taken but fold did not start");

    a_stall_holds_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcm_pkg::S_SUM && o_out_valid && !i_out_ready)
        |=> (r_state == rcm_pkg::S_SUM) && $stable(r_running_sum))
        else $error("result dropped while output register was full");

    a_mismatch_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcm_pkg::S_SUM && w_out_free && !r_last)
        |=> o_out_valid && !o_sum_mismatch)
        else $error("mismatch flagged on a word that does not close a block");

endmodule

`default_nettype wire
